// File: rtl/timestamped_sample_resampler_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped sample resampler
// Each macro places one labeled concurrent assertion on clk with rst disable.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_SAMPLE_RESAMPLER_TOP_DEFINES_SVH
`define TIMESTAMPED_SAMPLE_RESAMPLER_TOP_DEFINES_SVH

// Same-cycle implication
`define TSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared constants and payload types of the timestamped sample resampler.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int RING_DEPTH  = 512;
  localparam int SAMPLE_BITS = 16;
  localparam int AXES        = 6;
  localparam int TIME_W      = 64;
  localparam int PERIOD_W    = 30;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(RING_DEPTH + 1);
  localparam int W_W         = 17;
  localparam int MIN_KEEP    = 2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]                 t;
    logic [AXES-1:0][SAMPLE_BITS-1:0]  v;
  } entry_t;

  typedef struct packed {
    logic                          kind;
    logic [TIME_W-1:0]             sample_time;
    logic signed [SAMPLE_BITS-1:0] accel_x_in;
    logic signed [SAMPLE_BITS-1:0] accel_y_in;
    logic signed [SAMPLE_BITS-1:0] accel_z_in;
    logic signed [SAMPLE_BITS-1:0] gyro_x_in;
    logic signed [SAMPLE_BITS-1:0] gyro_y_in;
    logic signed [SAMPLE_BITS-1:0] gyro_z_in;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]             grid_time_out;
    logic signed [SAMPLE_BITS-1:0] accel_x_out;
    logic signed [SAMPLE_BITS-1:0] accel_y_out;
    logic signed [SAMPLE_BITS-1:0] accel_z_out;
    logic signed [SAMPLE_BITS-1:0] gyro_x_out;
    logic signed [SAMPLE_BITS-1:0] gyro_y_out;
    logic signed [SAMPLE_BITS-1:0] gyro_z_out;
  } result_t;

endpackage

// File: rtl/timestamped_sample_resampler_top.sv
// ----------------------------------------------------------------------------
// timestamped_sample_resampler_top
// Resample six-axis inertial samples onto an even time grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise start; the transaction is taken at a clock
//   edge with start high and busy low. A sample (kind 0) is written into the
//   ring at that edge and busy stays low, so samples may follow back to back.
//   A tick (kind 1), once the grid is anchored and the ring is not empty,
//   advances the grid and keeps busy high while the ring is scanned.
//   Result: result_valid is high for exactly one cycle with result; the
//   receiver cannot stall and must take it in that cycle.
//   Configuration: cfg_data is written when cfg_valid is high (cfg_ready is
//   always high); write only while busy is low.
//   Tick sequence: a read state and a compare state per stored entry
//   scanned until the bracket is found, then a setup state, a restoring
//   divide (skipped when the weight is one or the bracket is not ordered)
//   and the interpolation (one shared multiplier; each axis passes through
//   a multiply state and an accumulate state). result_valid is registered
//   from the last accumulate. A drop-read and a drop-check state then follow
//   per dropped old entry, plus a final check. The ring's single read port
//   makes the scan serial, one entry at a time.
//   Reset clears the ring pointers, the grid and the period; ring contents
//   are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "timestamped_sample_resampler_top_defines.svh"

module timestamped_sample_resampler_top import tsr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  item_t               item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  output logic                result_valid,
  output result_t             result
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD       = 4'd1;
  localparam logic [3:0] S_CHK      = 4'd2;
  localparam logic [3:0] S_SETUP    = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_ACC      = 4'd6;
  localparam logic [3:0] S_DROP_RD  = 4'd7;
  localparam logic [3:0] S_DROP_CHK = 4'd8;

  localparam int AX_W   = $clog2(AXES);
  localparam int PROD_W = SAMPLE_BITS + 1 + W_W + 1;

  logic [3:0]          state;
  logic [PERIOD_W-1:0] period;
  logic [PTR_W-1:0]    oldest;
  logic [CNT_W-1:0]    count;
  logic                started;
  logic [TIME_W-1:0]   grid_time;
  logic [CNT_W-1:0]    idx;
  entry_t              prev;
  entry_t              first;
  entry_t              ea;
  entry_t              eb;
  logic [TIME_W-1:0]   ta;
  logic [TIME_W-1:0]   rem;
  logic [TIME_W-1:0]   den;
  logic [W_W-1:0]      w;
  logic [3:0]          step;
  logic [AX_W-1:0]     ax;
  logic signed [PROD_W-1:0] prod;
  logic [AXES-1:0][SAMPLE_BITS-1:0] res_v;

  logic             we;
  logic [PTR_W-1:0] waddr;
  entry_t           wdata;
  logic [PTR_W-1:0] raddr;
  entry_t           rdata;

  logic [PTR_W:0]    scan_sum;
  logic [PTR_W-1:0]  scan_addr;
  logic [PTR_W:0]    app_sum;
  logic [PTR_W-1:0]  app_addr;
  logic [PTR_W-1:0]  oldest_inc;
  logic [TIME_W:0]   rem2;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [PROD_W-1:0]    rnd;
  logic              accept;

  tsr_ring u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Wrap ring addresses for any depth
  always_comb begin
    scan_sum = {1'b0, oldest} + {1'b0, idx[PTR_W-1:0]};
    if (scan_sum >= (PTR_W+1)'(RING_DEPTH)) begin
      scan_sum = scan_sum - (PTR_W+1)'(RING_DEPTH);
    end
    scan_addr = scan_sum[PTR_W-1:0];
    app_sum = {1'b0, oldest} + {1'b0, count[PTR_W-1:0]};
    if (app_sum >= (PTR_W+1)'(RING_DEPTH)) begin
      app_sum = app_sum - (PTR_W+1)'(RING_DEPTH);
    end
    app_addr = app_sum[PTR_W-1:0];
    if (oldest == PTR_W'(RING_DEPTH - 1)) begin
      oldest_inc = '0;
    end else begin
      oldest_inc = oldest + PTR_W'(1);
    end
  end

  // Append samples, select read address
  always_comb begin
    we          = accept && (item.kind == KIND_SAMPLE);
    waddr       = (count < CNT_W'(RING_DEPTH)) ? app_addr : oldest;
    wdata.t     = item.sample_time;
    wdata.v[0]  = item.accel_x_in;
    wdata.v[1]  = item.accel_y_in;
    wdata.v[2]  = item.accel_z_in;
    wdata.v[3]  = item.gyro_x_in;
    wdata.v[4]  = item.gyro_y_in;
    wdata.v[5]  = item.gyro_z_in;
    raddr       = (state == S_RD) ? scan_addr : oldest;
  end

  // Datapath helpers: divide step, axis difference, rounding
  always_comb begin
    rem2 = {rem, 1'b0};
    diff = $signed({eb.v[ax][SAMPLE_BITS-1], eb.v[ax]})
         - $signed({ea.v[ax][SAMPLE_BITS-1], ea.v[ax]});
    rnd  = prod + PROD_W'(32768);
  end

  // Control and datapath sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      period       <= '0;
      oldest       <= '0;
      count        <= '0;
      started      <= 1'b0;
      grid_time    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        period <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && item.kind == KIND_SAMPLE) begin
            if (count < CNT_W'(RING_DEPTH)) begin
              count <= count + CNT_W'(1);
            end else begin
              oldest <= oldest_inc;
            end
            if (!started && period != '0) begin
              grid_time <= item.sample_time;
              started   <= 1'b1;
            end
          end else if (accept && started && count != '0) begin
            grid_time <= grid_time + TIME_W'(period);
            idx       <= '0;
            state     <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          prev <= rdata;
          if (idx == '0) begin
            first <= rdata;
            if (count == CNT_W'(1)) begin
              ea    <= rdata;
              eb    <= rdata;
              state <= S_SETUP;
            end else begin
              idx   <= CNT_W'(1);
              state <= S_RD;
            end
          end else if (prev.t <= grid_time && grid_time <= rdata.t) begin
            ea    <= prev;
            eb    <= rdata;
            state <= S_SETUP;
          end else if (idx == count - CNT_W'(1)) begin
            // Hold oldest or newest when the grid lies outside them, else give no result
            if (grid_time < first.t) begin
              ea    <= first;
              eb    <= first;
              state <= S_SETUP;
            end else if (grid_time > rdata.t) begin
              ea    <= rdata;
              eb    <= rdata;
              state <= S_SETUP;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_RD;
          end
        end
        S_SETUP: begin
          ta  <= ea.t;
          ax  <= '0;
          if (eb.t > ea.t) begin
            rem  <= grid_time - ea.t;
            den  <= eb.t - ea.t;
            if ((grid_time - ea.t) >= (eb.t - ea.t)) begin
              w     <= W_W'(65536);
              state <= S_MUL;
            end else begin
              w     <= '0;
              step  <= '0;
              state <= S_DIV;
            end
          end else begin
            // Pass the later sample through
            ea.v  <= eb.v;
            w     <= '0;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, den}) begin
            rem <= TIME_W'(rem2 - {1'b0, den});
            w   <= {w[W_W-2:0], 1'b1};
          end else begin
            rem <= rem2[TIME_W-1:0];
            w   <= {w[W_W-2:0], 1'b0};
          end
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(diff) * PROD_W'($signed({1'b0, w}));
          state <= S_ACC;
        end
        S_ACC: begin
          res_v[ax] <= ea.v[ax] + rnd[SAMPLE_BITS+15:16];
          if (ax == AX_W'(AXES - 1)) begin
            result_valid <= 1'b1;
            state        <= S_DROP_RD;
          end else begin
            ax    <= ax + AX_W'(1);
            state <= S_MUL;
          end
        end
        S_DROP_RD: begin
          if (count > CNT_W'(MIN_KEEP)) begin
            state <= S_DROP_CHK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DROP_CHK: begin
          if (rdata.t < ta) begin
            oldest <= oldest_inc;
            count  <= count - CNT_W'(1);
            state  <= S_DROP_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drive the result transaction
  always_comb begin
    result.grid_time_out = grid_time;
    result.accel_x_out   = res_v[0];
    result.accel_y_out   = res_v[1];
    result.accel_z_out   = res_v[2];
    result.gyro_x_out    = res_v[3];
    result.gyro_y_out    = res_v[4];
    result.gyro_z_out    = res_v[5];
  end

  `TSR_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(RING_DEPTH), "ring count overflow")
  `TSR_ASSERT_IMPL(a_oldest_bound, 1'b1, oldest <= PTR_W'(RING_DEPTH - 1), "oldest slot out of range")
  `TSR_ASSERT_IMPL(a_result_busy, result_valid, state == S_DROP_RD, "result outside emit")
  `TSR_ASSERT_NEXT(a_tick_busy, accept && item.kind == KIND_TICK && started && count != '0, busy, "tick not taken")
  `TSR_ASSERT_NEXT(a_drop_keep, state == S_DROP_CHK, count >= CNT_W'(MIN_KEEP), "dropped too many entries")

endmodule

// File: rtl/tsr_ring.sv
// ----------------------------------------------------------------------------
// tsr_ring
// Sample ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsr_ring import tsr_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [PTR_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [PTR_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [RING_DEPTH];

  // Write the new sample
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the timestamped sample resampler
// Drives sample and tick transactions with random gaps and checks each
// result against a predictor of the ring, the grid and the interpolation.
// Covers several grid periods, the grid wrapping past 2^64, and a full ring.
// ----------------------------------------------------------------------------
module tb;
  import tsr_pkg::*;

  localparam int TICK_CYCLES = 1100;

  // Predictor of the resampler and store of pending grid results
  class resample_scoreboard;
    entry_t              ring [RING_DEPTH];
    int unsigned         head;
    int unsigned         count;
    bit                  started;
    logic [TIME_W-1:0]   grid;
    logic [PERIOD_W-1:0] period;
    result_t             pending [$];
    int                  errors;

    function new();
      head = 0;
      count = 0;
      started = 0;
      grid = '0;
      period = '0;
      errors = 0;
    endfunction

    function entry_t slot(int unsigned i);
      return ring[(head + i) % RING_DEPTH];
    endfunction

    // Q1.16 weight, capped at one when the grid sits on the upper sample
    function logic [16:0] weight(logic [TIME_W-1:0] num, logic [TIME_W-1:0] den);
      logic [TIME_W+15:0] quo;
      if (num >= den) return 17'h10000;
      quo = {num, 16'h0} / {16'h0, den};
      return quo[16:0];
    endfunction

    function logic [SAMPLE_BITS-1:0] blend(logic [SAMPLE_BITS-1:0] a,
                                           logic [SAMPLE_BITS-1:0] b,
                                           logic [16:0] w);
      longint p;
      p = (longint'($signed(b)) - longint'($signed(a))) * longint'({15'h0, w}) + 32768;
      return SAMPLE_BITS'(longint'($signed(a)) + (p >>> 16));
    endfunction

    // Update the model for one accepted transaction and queue any result
    function void note_input(item_t it);
      entry_t e;
      entry_t a;
      entry_t b;
      result_t r;
      logic [SAMPLE_BITS-1:0] o [AXES];
      logic [16:0] w;
      int unsigned ia;
      int unsigned ib;
      bit found;
      if (it.kind == KIND_SAMPLE) begin
        e.t = it.sample_time;
        e.v[0] = it.accel_x_in;
        e.v[1] = it.accel_y_in;
        e.v[2] = it.accel_z_in;
        e.v[3] = it.gyro_x_in;
        e.v[4] = it.gyro_y_in;
        e.v[5] = it.gyro_z_in;
        if (count < RING_DEPTH) begin
          ring[(head + count) % RING_DEPTH] = e;
          count++;
        end else begin
          ring[head] = e;
          head = (head + 1) % RING_DEPTH;
        end
        if (!started && period != 0) begin
          grid = e.t;
          started = 1;
        end
        return;
      end
      if (!started || count == 0) return;
      grid += {34'h0, period};
      ia = 0;
      ib = 0;
      found = 0;
      if (count == 1) begin
        found = 1;
      end else begin
        for (int unsigned i = 1; i < count && !found; i++) begin
          if (slot(i - 1).t <= grid && grid <= slot(i).t) begin
            ia = i - 1;
            ib = i;
            found = 1;
          end
        end
        if (!found) begin
          if (grid < slot(0).t) begin
            found = 1;
          end else if (grid > slot(count - 1).t) begin
            ia = count - 1;
            ib = count - 1;
            found = 1;
          end
        end
      end
      if (!found) return;
      a = slot(ia);
      b = slot(ib);
      // Interpolate when the bracket is ordered, else pass the later sample
      if (b.t > a.t) begin
        w = weight(grid - a.t, b.t - a.t);
        for (int j = 0; j < AXES; j++) o[j] = blend(a.v[j], b.v[j], w);
      end else begin
        for (int j = 0; j < AXES; j++) o[j] = b.v[j];
      end
      r.grid_time_out = grid;
      r.accel_x_out = o[0];
      r.accel_y_out = o[1];
      r.accel_z_out = o[2];
      r.gyro_x_out  = o[3];
      r.gyro_y_out  = o[4];
      r.gyro_z_out  = o[5];
      pending.insert(pending.size(), r);
      // Drop entries older than the lower bracket, keeping at least two
      while (count > MIN_KEEP && slot(0).t < a.t) begin
        head = (head + 1) % RING_DEPTH;
        count--;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      logic [TIME_W-1:0] wv [7];
      logic [TIME_W-1:0] gv [7];
      string names [7];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, got);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      names = '{"grid_time_out", "accel_x_out", "accel_y_out", "accel_z_out",
                "gyro_x_out", "gyro_y_out", "gyro_z_out"};
      wv = '{want.grid_time_out, want.accel_x_out, want.accel_y_out, want.accel_z_out,
             want.gyro_x_out, want.gyro_y_out, want.gyro_z_out};
      gv = '{got.grid_time_out, got.accel_x_out, got.accel_y_out, got.accel_z_out,
             got.gyro_x_out, got.gyro_y_out, got.gyro_z_out};
      for (int k = 0; k < 7; k++) begin
        if (wv[k] !== gv[k]) begin
          $display("%0t: %s mismatch, expected %h, actual %h", $time, names[k], wv[k], gv[k]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  item_t               item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data;
  logic                result_valid;
  result_t             result;

  resample_scoreboard sb;
  bit                 no_gaps;
  logic [TIME_W-1:0]  stamp;

  timestamped_sample_resampler_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Collect results at the edge that ends their cycle
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  function int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hold the transaction until accepted, then idle or keep start high
  task automatic send(item_t it);
    int unsigned n;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    n = pick_gap();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_sample(logic [TIME_W-1:0] t, bit pin, logic [SAMPLE_BITS-1:0] val);
    item_t it;
    it = item_t'(($bits(item_t))'({$urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom}));
    it.kind = KIND_SAMPLE;
    it.sample_time = t;
    if (pin) begin
      it.accel_x_in = val;
      it.accel_y_in = val;
      it.accel_z_in = val;
      it.gyro_x_in  = val;
      it.gyro_y_in  = val;
      it.gyro_z_in  = val;
    end
    send(it);
  endtask

  task automatic send_tick();
    item_t it;
    it = item_t'(($bits(item_t))'({$urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom}));
    it.kind = KIND_TICK;
    send(it);
  endtask

  // Let the block settle, then write the grid period
  task automatic set_period(logic [PERIOD_W-1:0] p);
    start <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (TICK_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.period = p;
  endtask

  // Mostly ordered samples trailing the grid, with a share of stray ones
  task automatic run_phase(logic [PERIOD_W-1:0] p, int n, bit burst);
    logic [TIME_W-1:0] step;
    set_period(p);
    no_gaps = burst;
    stamp = sb.grid;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 1)) send_sample({$urandom, $urandom}, 0, '0);
        else send_sample(sb.grid - $urandom_range(0, 5000), 0, '0);
      end else if ($urandom_range(0, 1)) begin
        send_tick();
      end else begin
        step = $urandom_range(0, 2 * p + 1);
        stamp += step;
        send_sample(stamp, 0, '0);
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    logic [TIME_W-1:0] base;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_gaps = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: anchor high so the grid later wraps past 2^64
    base = 64'hFFFF_FFFF_F000_0000;
    send_tick();                                  // before anchor: nothing
    send_sample(base + 9000, 1, 16'h7FFF);        // period zero: no anchor
    set_period(30'd1000);
    send_sample(base + 1000, 1, 16'h8000);        // anchors the grid
    send_tick();                                  // grid before oldest
    send_sample(base + 3000, 0, '0);
    send_tick();                                  // grid on upper sample
    send_sample(base + 3000, 1, 16'h0000);        // equal timestamps
    send_sample(base + 5000, 1, 16'hFFFF);
    send_tick();                                  // interpolate
    send_tick();
    send_tick();                                  // grid after newest
    set_period(30'd0);
    send_tick();                                  // grid repeats
    send_tick();
    set_period(30'd1000);
    send_sample(base + 7000, 1, 16'h7FFF);
    send_sample(base + 8000, 1, 16'h8000);
    send_tick();
    send_sample(base + 9500, 1, 16'h8000);
    send_sample(base + 10500, 1, 16'h7FFF);
    send_tick();
    send_tick();
    send_tick();

    // Random phases over several periods; the widest ones carry the grid past 2^64
    run_phase(30'd1000, 10, 0);
    run_phase(30'd1, 6, 1);
    run_phase(30'd1_000_000_000, 8, 0);
    run_phase(30'h3FFF_FFFF, 8, 0);
    run_phase(30'($urandom_range(2, 1_000_000)), 6, 0);
    run_phase(30'd0, 4, 1);
    run_phase(30'd7, 6, 0);

    // Fill the ring past its depth, then tick across the full ring
    set_period(30'd1);
    stamp = sb.grid;
    for (int i = 0; i < RING_DEPTH + 8; i++) begin
      stamp += $urandom_range(0, 2);
      send_sample(stamp, 0, '0);
    end
    for (int i = 0; i < 8; i++) send_tick();

    start <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (TICK_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: timestamped_sample_resampler_top.f
+incdir+rtl
rtl/tsr_pkg.sv
rtl/tsr_ring.sv
rtl/timestamped_sample_resampler_top.sv
test/tb.sv
